// ===== rtl/srcc_pkg.sv =====
// ----------------------------------------------------------------------------
// srcc_pkg: shared types and constants for the sparse row-to-column transpose
// Word layouts, request and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package srcc_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int MAX_NZ_DEF  = 4096;

  localparam int CFG_W  = 11;
  localparam int IDX_W  = 10;
  localparam int RIDX_W = 13;
  localparam int PTR_W  = 13;
  localparam int VAL_W  = 64;

  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RD_PTR = 2'd1,
    REQ_RD_ENT = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_COL = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_IDX = 2'd3
  } stat_t;

  typedef struct packed {
    req_t              req_type;
    logic [IDX_W-1:0]  row_in;
    logic [IDX_W-1:0]  col_in;
    logic [VAL_W-1:0]  value_in;
    logic              last_in;
    logic [RIDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [PTR_W-1:0] pointer_out;
    logic [IDX_W-1:0] row_out;
    logic [VAL_W-1:0] value_out;
    stat_t            status_out;
  } out_item_t;

  // loaded nonzero, kept in load order
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } ld_entry_t;

  // converted entry, kept in column order
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [VAL_W-1:0] value;
  } cv_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_CLR,
    S_LD_UPD,
    S_RD_PTR,
    S_RD_ENT,
    S_PFX_FIRST,
    S_PFX,
    S_PFX_LAST,
    S_SC_START,
    S_SC_PTR,
    S_SC_WR
  } state_t;

endpackage

// ===== rtl/sparse_row_to_column_transpose_top.sv =====
// ----------------------------------------------------------------------------
// sparse_row_to_column_transpose_top: row-major to column-major sparse convert
// Counting-sort transpose of storage order with column pointer and entry reads.
// ----------------------------------------------------------------------------
//
//  channel   ports                        handshake
//  --------  ---------------------------  ----------------------------------
//  input     start, busy, in_data         word taken when start & !busy
//  result    out_valid, out_data          one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata            matrix_size written when cfg_we
//
//  Load or read word: checked in S_CHK, answered from S_LD_UPD, S_RD_PTR or
//  S_RD_ENT; a word failing its range check from S_CHK; request type 3: no result.
//  First load after reset or after a conversion clears the pointer RAM first.
//  last_in adds a prefix-sum pass and a scatter of each stored nonzero,
//  bound by the one pointer RAM read port; busy covers all of it.
//  Reset is synchronous; the receiver cannot stall, so results never wait.
//
module sparse_row_to_column_transpose_top #(
  parameter int MAX_DIM      = srcc_pkg::MAX_DIM_DEF,
  parameter int MAX_NONZEROS = srcc_pkg::MAX_NZ_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  srcc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output srcc_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [srcc_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int PAW = $clog2(MAX_DIM + 1);
  localparam int SW  = (srcc_pkg::CFG_W > PAW) ? srcc_pkg::CFG_W : PAW;

  logic [srcc_pkg::CFG_W-1:0] size_r;
  logic [SW-1:0]              size_x;
  logic [PAW-1:0]             n_eff;
  logic                       eng_busy;
  logic                       accept;
  logic                       res_vld;
  srcc_pkg::out_item_t        res;
  logic                       out_valid_r;
  srcc_pkg::out_item_t        out_data_r;

  // matrix_size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= srcc_pkg::CFG_SIZE_RST;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // zero acts as 1, oversize saturates at MAX_DIM
  assign size_x = SW'(size_r);
  always_comb begin
    if (size_x == '0) begin
      n_eff = PAW'(1);
    end else if (size_x > SW'(MAX_DIM)) begin
      n_eff = PAW'(MAX_DIM);
    end else begin
      n_eff = PAW'(size_x);
    end
  end

  assign accept = start & ~eng_busy;
  assign busy   = eng_busy;

  srcc_engine #(
    .MAX_DIM(MAX_DIM),
    .MAX_NONZEROS(MAX_NONZEROS)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .start_i(accept),
    .item_i(in_data),
    .n_eff_i(n_eff),
    .busy_o(eng_busy),
    .res_vld_o(res_vld),
    .res_o(res)
  );

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/srcc_ram.sv =====
// ----------------------------------------------------------------------------
// srcc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srcc_engine.sv =====
// ----------------------------------------------------------------------------
// srcc_engine: sequencer and shared pointer adder
// Owns the load, pointer and converted stores; clears, counts, prefix-sums
// and scatters; all but the clear use one adder on the pointer RAM read port.
// ----------------------------------------------------------------------------
module srcc_engine #(
  parameter int MAX_DIM     = srcc_pkg::MAX_DIM_DEF,
  parameter int MAX_NONZEROS = srcc_pkg::MAX_NZ_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  srcc_pkg::in_item_t         item_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] n_eff_i,
  output logic                       busy_o,
  output logic                       res_vld_o,
  output srcc_pkg::out_item_t        res_o
);

  localparam int PAW  = $clog2(MAX_DIM + 1);
  localparam int NZAW = $clog2(MAX_NONZEROS);
  localparam int NZW  = $clog2(MAX_NONZEROS + 1);
  localparam int CW0  = (NZW > srcc_pkg::RIDX_W) ? NZW : srcc_pkg::RIDX_W;
  localparam int CW   = (PAW > CW0) ? PAW : CW0;
  localparam int PTRW = srcc_pkg::PTR_W;

  srcc_pkg::state_t   state_r, state_nxt;
  srcc_pkg::in_item_t item_r, item_nxt;
  logic [PAW-1:0]     k_r, k_nxt;
  logic [NZW-1:0]     e_r, e_nxt;
  logic [NZW-1:0]     run_r, run_nxt;
  logic [NZW-1:0]     cnt_r, cnt_nxt;
  logic               conv_r, conv_nxt;
  logic               clrp_r, clrp_nxt;

  // pointer RAM
  logic               p_we;
  logic [PAW-1:0]     p_waddr, p_raddr;
  logic [NZW-1:0]     p_wdata, p_rdata;
  // load store
  logic               l_we;
  logic [NZAW-1:0]    l_waddr, l_raddr;
  srcc_pkg::ld_entry_t l_wdata, l_rdata;
  // converted store
  logic               c_we;
  logic [NZAW-1:0]    c_waddr, c_raddr;
  srcc_pkg::cv_entry_t c_wdata, c_rdata;

  // shared adder
  logic [NZW-1:0]     add_a, add_sum;
  logic [PAW-1:0]     slot_item, slot_ld;
  logic [CW-1:0]      n_x, ridx_x;
  logic [NZW-1:0]     e_inc;

  assign add_a   = (state_r == srcc_pkg::S_PFX || state_r == srcc_pkg::S_PFX_LAST)
                   ? run_r : NZW'(1);
  assign add_sum = add_a + p_rdata;

  assign slot_item = PAW'(item_r.col_in) + PAW'(1);
  assign slot_ld   = PAW'(l_rdata.col) + PAW'(1);
  assign n_x       = CW'(n_eff_i);
  assign ridx_x    = CW'(item_r.read_index);
  assign e_inc     = e_r + NZW'(1);

  assign busy_o = (state_r != srcc_pkg::S_IDLE);

  srcc_ram #(.WIDTH(NZW), .DEPTH(MAX_DIM + 1)) u_ptr_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  srcc_ram #(.WIDTH($bits(srcc_pkg::ld_entry_t)), .DEPTH(MAX_NONZEROS)) u_ld_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  srcc_ram #(.WIDTH($bits(srcc_pkg::cv_entry_t)), .DEPTH(MAX_NONZEROS)) u_cv_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srcc_pkg::S_IDLE;
      cnt_r   <= '0;
      conv_r  <= 1'b0;
      clrp_r  <= 1'b1;
      k_r     <= '0;
      e_r     <= '0;
      run_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      conv_r  <= conv_nxt;
      clrp_r  <= clrp_nxt;
      k_r     <= k_nxt;
      e_r     <= e_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    k_nxt     = k_r;
    e_nxt     = e_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    conv_nxt  = conv_r;
    clrp_nxt  = clrp_r;

    p_we    = 1'b0;
    p_waddr = k_r;
    p_wdata = '0;
    p_raddr = k_r;

    l_we       = 1'b0;
    l_waddr    = NZAW'(cnt_r);
    l_wdata.row   = item_r.row_in;
    l_wdata.col   = item_r.col_in;
    l_wdata.value = item_r.value_in;
    l_raddr    = NZAW'(e_r);

    c_we          = 1'b0;
    c_waddr       = NZAW'(p_rdata);
    c_wdata.row   = l_rdata.row;
    c_wdata.value = l_rdata.value;
    c_raddr       = NZAW'(item_r.read_index);

    res_vld_o = 1'b0;
    res_o     = '0;

    case (state_r)
      srcc_pkg::S_IDLE: begin
        if (start_i) begin
          item_nxt = item_i;
          case (item_i.req_type)
            srcc_pkg::REQ_LOAD: begin
              if (clrp_r) begin
                // new matrix: wipe counts first
                state_nxt = srcc_pkg::S_CLR;
                k_nxt     = '0;
                cnt_nxt   = '0;
                conv_nxt  = 1'b0;
              end else begin
                state_nxt = srcc_pkg::S_CHK;
              end
            end
            srcc_pkg::REQ_RD_PTR, srcc_pkg::REQ_RD_ENT: begin
              state_nxt = srcc_pkg::S_CHK;
            end
            default: begin
              state_nxt = srcc_pkg::S_IDLE;
            end
          endcase
        end
      end

      srcc_pkg::S_CLR: begin
        p_we    = 1'b1;
        p_waddr = k_r;
        p_wdata = '0;
        if (k_r == PAW'(MAX_DIM)) begin
          clrp_nxt  = 1'b0;
          state_nxt = srcc_pkg::S_CHK;
        end else begin
          k_nxt = k_r + PAW'(1);
        end
      end

      srcc_pkg::S_CHK: begin
        case (item_r.req_type)
          srcc_pkg::REQ_LOAD: begin
            p_raddr = slot_item;
            if (CW'(item_r.col_in) >= n_x) begin
              res_vld_o        = 1'b1;
              res_o.status_out = srcc_pkg::ST_BAD_COL;
              state_nxt        = item_r.last_in ? srcc_pkg::S_PFX_FIRST : srcc_pkg::S_IDLE;
            end else if (cnt_r == NZW'(MAX_NONZEROS)) begin
              res_vld_o        = 1'b1;
              res_o.status_out = srcc_pkg::ST_FULL;
              state_nxt        = item_r.last_in ? srcc_pkg::S_PFX_FIRST : srcc_pkg::S_IDLE;
            end else begin
              state_nxt = srcc_pkg::S_LD_UPD;
            end
            k_nxt   = PAW'(1);
            run_nxt = '0;
          end
          srcc_pkg::REQ_RD_PTR: begin
            p_raddr = PAW'(item_r.read_index);
            if (conv_r && (ridx_x <= n_x)) begin
              state_nxt = srcc_pkg::S_RD_PTR;
            end else begin
              res_vld_o        = 1'b1;
              res_o.status_out = srcc_pkg::ST_BAD_IDX;
              state_nxt        = srcc_pkg::S_IDLE;
            end
          end
          srcc_pkg::REQ_RD_ENT: begin
            if (conv_r && (ridx_x < CW'(cnt_r))) begin
              state_nxt = srcc_pkg::S_RD_ENT;
            end else begin
              res_vld_o        = 1'b1;
              res_o.status_out = srcc_pkg::ST_BAD_IDX;
              state_nxt        = srcc_pkg::S_IDLE;
            end
          end
          default: begin
            state_nxt = srcc_pkg::S_IDLE;
          end
        endcase
      end

      srcc_pkg::S_LD_UPD: begin
        // bump column count, store nonzero at the fill index
        p_we      = 1'b1;
        p_waddr   = slot_item;
        p_wdata   = add_sum;
        l_we      = 1'b1;
        cnt_nxt   = cnt_r + NZW'(1);
        res_vld_o = 1'b1;
        state_nxt = item_r.last_in ? srcc_pkg::S_PFX_FIRST : srcc_pkg::S_IDLE;
      end

      srcc_pkg::S_RD_PTR: begin
        res_vld_o         = 1'b1;
        res_o.pointer_out = PTRW'(p_rdata);
        state_nxt         = srcc_pkg::S_IDLE;
      end

      srcc_pkg::S_RD_ENT: begin
        res_vld_o       = 1'b1;
        res_o.row_out   = c_rdata.row;
        res_o.value_out = c_rdata.value;
        state_nxt       = srcc_pkg::S_IDLE;
      end

      srcc_pkg::S_PFX_FIRST: begin
        p_raddr   = k_r;
        k_nxt     = k_r + PAW'(1);
        state_nxt = srcc_pkg::S_PFX;
      end

      // read slot k while writing slot k-1 with the running sum
      srcc_pkg::S_PFX: begin
        p_raddr = k_r;
        p_we    = 1'b1;
        p_waddr = k_r - PAW'(1);
        p_wdata = run_r;
        run_nxt = add_sum;
        if (k_r == PAW'(MAX_DIM)) begin
          state_nxt = srcc_pkg::S_PFX_LAST;
        end else begin
          k_nxt = k_r + PAW'(1);
        end
      end

      srcc_pkg::S_PFX_LAST: begin
        p_we    = 1'b1;
        p_waddr = k_r;
        p_wdata = run_r;
        e_nxt   = '0;
        if (cnt_r == '0) begin
          conv_nxt  = 1'b1;
          clrp_nxt  = 1'b1;
          state_nxt = srcc_pkg::S_IDLE;
        end else begin
          state_nxt = srcc_pkg::S_SC_START;
        end
      end

      srcc_pkg::S_SC_START: begin
        l_raddr   = NZAW'(e_r);
        state_nxt = srcc_pkg::S_SC_PTR;
      end

      srcc_pkg::S_SC_PTR: begin
        l_raddr   = NZAW'(e_r);
        p_raddr   = slot_ld;
        state_nxt = srcc_pkg::S_SC_WR;
      end

      srcc_pkg::S_SC_WR: begin
        p_we    = 1'b1;
        p_waddr = slot_ld;
        p_wdata = add_sum;
        c_we    = 1'b1;
        l_raddr = NZAW'(e_inc);
        if (e_inc == cnt_r) begin
          conv_nxt  = 1'b1;
          clrp_nxt  = 1'b1;
          state_nxt = srcc_pkg::S_IDLE;
        end else begin
          e_nxt     = e_inc;
          state_nxt = srcc_pkg::S_SC_PTR;
        end
      end

      default: begin
        state_nxt = srcc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/sparse_row_to_column_transpose_top_tb.sv =====
// ----------------------------------------------------------------------------
// sparse_row_to_column_transpose_top_tb: self-checking bench for the transpose
// Streams load and read words into the block, predicts each reply with a
// counting-sort transpose kept inside the bench and checks every reply word.
// ----------------------------------------------------------------------------
module sparse_row_to_column_transpose_top_tb;

  localparam int SETTLE_CYCLES  = 8;     // a bit over the load latency
  localparam int WATCHDOG_LIMIT = 40000; // outlasts clear + prefix + full-store scatter
  localparam int RANDOM_WORDS   = 400;

  localparam int CFG_W       = srcc_pkg::CFG_W;
  localparam int IDX_W       = srcc_pkg::IDX_W;
  localparam int RIDX_W      = srcc_pkg::RIDX_W;
  localparam int PTR_W       = srcc_pkg::PTR_W;
  localparam int VAL_W       = srcc_pkg::VAL_W;
  localparam int MAX_DIM_DEF = srcc_pkg::MAX_DIM_DEF;
  localparam int MAX_NZ_DEF  = srcc_pkg::MAX_NZ_DEF;

  // DUT hookup, all inputs known from time zero
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  srcc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  srcc_pkg::out_item_t out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = srcc_pkg::CFG_SIZE_RST;

  sparse_row_to_column_transpose_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  srcc_pkg::in_item_t  request_q[$];        // words waiting for the driver
  srcc_pkg::out_item_t pending_replies[$];  // predicted replies, oldest first
  int        gap_pct = 15;        // chance per cycle that the driver holds off
  int        mismatch_count = 0;
  int        idle_cycles = 0;

  // Transpose model: its own copy of size register, counts and both stores
  logic [CFG_W-1:0] size_reg;
  int unsigned      col_ptr [0:MAX_DIM_DEF];   // counts, then column starts
  logic [IDX_W-1:0] ld_row  [0:MAX_NZ_DEF-1];
  logic [IDX_W-1:0] ld_col  [0:MAX_NZ_DEF-1];
  logic [VAL_W-1:0] ld_val  [0:MAX_NZ_DEF-1];
  logic [IDX_W-1:0] cv_row  [0:MAX_NZ_DEF-1];
  logic [VAL_W-1:0] cv_val  [0:MAX_NZ_DEF-1];
  int unsigned      nz_count;
  bit               converted;

  // coverage tallies for the summary
  int loads_kept = 0, loads_dropped = 0, ptr_reads = 0, ent_reads = 0;
  int conversions = 0, size_writes = 0;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  // Advance the model by one accepted word; returns 1 when a reply is due.
  function automatic bit transpose_word(input srcc_pkg::in_item_t w,
                                        output srcc_pkg::out_item_t r);
    int unsigned n, run, cnt, slot, pos;
    n = clamp_size(size_reg);
    r = '0;
    case (w.req_type)
      srcc_pkg::REQ_NONE: return 0;
      srcc_pkg::REQ_LOAD: begin
        // first load after a conversion opens a new matrix
        if (converted) begin
          foreach (col_ptr[k]) col_ptr[k] = 0;
          nz_count = 0;
          converted = 0;
        end
        if (w.col_in >= n) begin
          r.status_out = srcc_pkg::ST_BAD_COL;
          loads_dropped++;
        end else if (nz_count >= MAX_NZ_DEF) begin
          r.status_out = srcc_pkg::ST_FULL;
          loads_dropped++;
        end else begin
          ld_row[nz_count] = w.row_in;
          ld_col[nz_count] = w.col_in;
          ld_val[nz_count] = w.value_in;
          nz_count++;
          col_ptr[int'(w.col_in) + 1]++;
          loads_kept++;
        end
        // last converts even when the word itself was dropped
        if (w.last_in) begin
          run = 0;
          for (int k = 1; k <= MAX_DIM_DEF; k++) begin
            cnt = col_ptr[k];
            col_ptr[k] = run;
            run += cnt;
          end
          col_ptr[0] = 0;
          // scatter in load order; slot pointer ends at the next column start
          for (int e = 0; e < nz_count; e++) begin
            slot = int'(ld_col[e]) + 1;
            pos = col_ptr[slot];
            if (pos < MAX_NZ_DEF) begin
              cv_row[pos] = ld_row[e];
              cv_val[pos] = ld_val[e];
            end
            col_ptr[slot] = pos + 1;
          end
          converted = 1;
          conversions++;
        end
      end
      srcc_pkg::REQ_RD_PTR: begin
        ptr_reads++;
        if (converted && w.read_index <= n) r.pointer_out = PTR_W'(col_ptr[w.read_index]);
        else r.status_out = srcc_pkg::ST_BAD_IDX;
      end
      default: begin
        ent_reads++;
        if (converted && w.read_index < nz_count && w.read_index < MAX_NZ_DEF) begin
          r.row_out = cv_row[w.read_index];
          r.value_out = cv_val[w.read_index];
        end else begin
          r.status_out = srcc_pkg::ST_BAD_IDX;
        end
      end
    endcase
    return 1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one word per handshake, random hold-off between words.
  // start only ever gets one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        in_data <= request_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the reply strobe first, then predict the word taken at
  // this edge (a reply never shows up in the cycle its word is taken).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    srcc_pkg::out_item_t want, got;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("reply word %h with nothing expected", out_data));
        end else begin
          want = pending_replies.pop_front();
          if (out_data.pointer_out !== want.pointer_out)
            report_mismatch($sformatf("pointer_out %0d, expected %0d",
                                      out_data.pointer_out, want.pointer_out));
          if (out_data.row_out !== want.row_out)
            report_mismatch($sformatf("row_out %0d, expected %0d",
                                      out_data.row_out, want.row_out));
          if (out_data.value_out !== want.value_out)
            report_mismatch($sformatf("value_out %h, expected %h",
                                      out_data.value_out, want.value_out));
          if (out_data.status_out !== want.status_out)
            report_mismatch($sformatf("status_out %0d, expected %0d",
                                      out_data.status_out, want.status_out));
        end
      end
      if (start && !busy) begin
        if (transpose_word(in_data, got)) pending_replies.push_back(got);
      end
    end
  end

  // Watchdog: no word taken and no reply for too long ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic srcc_pkg::in_item_t load_word(input int unsigned row,
                                                   input int unsigned col,
                                                   input logic [VAL_W-1:0] val,
                                                   input bit last);
    srcc_pkg::in_item_t w;
    w.req_type   = srcc_pkg::REQ_LOAD;
    w.row_in     = IDX_W'(row);
    w.col_in     = IDX_W'(col);
    w.value_in   = val;
    w.last_in    = last;
    w.read_index = RIDX_W'($urandom_range(0, 8191));  // ignored on loads
    return w;
  endfunction

  // read or unused word; every field other than the type and the index is junk
  function automatic srcc_pkg::in_item_t read_word(input srcc_pkg::req_t kind,
                                                   input int unsigned idx);
    srcc_pkg::in_item_t w;
    w.req_type   = kind;
    w.row_in     = IDX_W'($urandom_range(0, 1023));
    w.col_in     = IDX_W'($urandom_range(0, 1023));
    w.value_in   = {$urandom, $urandom};
    w.last_in    = 1'($urandom_range(0, 1));
    w.read_index = RIDX_W'(idx);
    return w;
  endfunction

  // size spread: extremes, the out-of-range encodings, small matrices and any encoding
  function automatic logic [CFG_W-1:0] random_size();
    case ($urandom_range(0, 5))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return 11'd0;
      3:       return 11'd2047;
      4:       return CFG_W'($urandom_range(2, 64));
      default: return CFG_W'($urandom_range(1, 2047));
    endcase
  endfunction

  // Hold the sender until every reply is in, then let the block finish any
  // clearing or conversion pass (busy covers those, unused words give no reply).
  task automatic settle();
    while (request_q.size() != 0 || start || pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    size_reg = v;
    size_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned nnz, split, row, gen_n, goal;
    int          random_words;
    random_words = 0;
    foreach (col_ptr[k]) col_ptr[k] = 0;
    nz_count = 0;
    converted = 0;
    size_reg = srcc_pkg::CFG_SIZE_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // -- directed, size at its reset value (1024) --
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 0));  // nothing converted yet
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 0));
    request_q.push_back(read_word(srcc_pkg::REQ_NONE, 8191)); // unused code, no reply
    request_q.push_back(load_word(0, 0, '0, 0));
    request_q.push_back(load_word(0, 1023, '1, 0));
    request_q.push_back(load_word(1023, 1023, {32{2'b10}}, 0));
    request_q.push_back(load_word(5, 3, {32{2'b01}}, 1));  // row order broken
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 0));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 1024));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 1025));  // past n
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 8191));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 0));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 3));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 4));     // equals entry count
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 8191));

    // small matrix: bad columns, and last on a dropped load
    write_size(11'd4);
    request_q.push_back(load_word(2, 4, {$urandom, $urandom}, 0));
    request_q.push_back(load_word(2, 3, {$urandom, $urandom}, 0));
    request_q.push_back(load_word(3, 0, {$urandom, $urandom}, 0));
    request_q.push_back(load_word(9, 1023, {$urandom, $urandom}, 1));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 4));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 5));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 1));

    // size 0 behaves as 1
    write_size(11'd0);
    request_q.push_back(load_word(0, 1, {$urandom, $urandom}, 0));
    request_q.push_back(load_word(0, 0, {$urandom, $urandom}, 1));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, 1));
    request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, 0));

    write_size(11'd2047);  // clamps to MAX_DIM

    // -- random matrices over three sender gap settings --
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      gap_pct = (phase == 0) ? 15 : (phase == 1) ? 57 : 0;
      goal = random_words + RANDOM_WORDS / 3 + 1;

      while (random_words < goal) begin
        if ($urandom_range(0, 99) < 40) write_size(random_size());
        gen_n = clamp_size(size_reg);
        nnz = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        // now and then the size moves while the matrix is still loading
        split = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nnz) : nnz + 1;
        row = $urandom_range(0, 1023) >> $urandom_range(0, 10);

        for (int k = 0; k < nnz; k++) begin
          if (k == split) begin
            write_size(random_size());
            gen_n = clamp_size(size_reg);
          end
          // noise between loads: unused codes and early reads
          case ($urandom_range(0, 39))
            0: request_q.push_back(read_word(srcc_pkg::REQ_NONE, $urandom_range(0, 8191)));
            1: begin
              request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, $urandom_range(0, gen_n)));
              random_words++;
            end
            default: ;
          endcase
          if ($urandom_range(0, 19) == 0) row = $urandom_range(0, 1023);
          else if (row < 1023) row = row + $urandom_range(0, 1);
          request_q.push_back(load_word(
              row,
              ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, gen_n - 1),
              {$urandom, $urandom},
              (k == nnz - 1) && ($urandom_range(0, 19) != 0)));
          random_words++;
        end

        repeat (nnz / 2 + $urandom_range(2, 8)) begin
          case ($urandom_range(0, 19))
            0: request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, $urandom_range(0, 8191)));
            1: request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, $urandom_range(0, 8191)));
            2, 3, 4, 5, 6, 7, 8, 9:
              request_q.push_back(read_word(srcc_pkg::REQ_RD_PTR, $urandom_range(0, gen_n)));
            default:
              request_q.push_back(read_word(srcc_pkg::REQ_RD_ENT, $urandom_range(0, nnz - 1)));
          endcase
          random_words++;
        end
      end
    end

    // drain, let any final conversion finish, then a short tail
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d kept and %0d dropped loads, %0d conversions, %0d pointer reads,",
             loads_kept, loads_dropped, conversions, ptr_reads);
    $display("  %0d entry reads, %0d size writes; %0d mismatches",
             ent_reads, size_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sparse_row_to_column_transpose_top.f =====
rtl/srcc_pkg.sv
rtl/srcc_ram.sv
rtl/srcc_engine.sv
rtl/sparse_row_to_column_transpose_top.sv
tb/sparse_row_to_column_transpose_top_tb.sv
